// ===== sv/srr_pkg.sv =====
package srr_pkg;

    localparam int CoordW = 47;
    localparam int NumW   = 72;
    localparam int QuotW  = 72;

    localparam logic [2:0] AddrFocal = 3'd0;
    localparam logic [2:0] AddrPx    = 3'd1;
    localparam logic [2:0] AddrPy    = 3'd2;
    localparam logic [2:0] AddrOff   = 3'd3;
    localparam logic [2:0] AddrRot0  = 3'd4;
    localparam logic [2:0] AddrRot1  = 3'd5;
    localparam logic [2:0] AddrRot2  = 3'd6;
    localparam logic [2:0] AddrTrans = 3'd7;

    typedef struct packed {
        logic [23:0] focal;
        logic [23:0] px;
        logic [23:0] py;
        logic signed [23:0] off;
        logic [53:0] rot0;
        logic [53:0] rot1;
        logic [53:0] rot2;
        logic [62:0] trans;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] ou;
        logic signed [31:0] ov;
        logic signed [31:0] oru;
        logic signed [31:0] orv;
        logic last;
    } side_t;

endpackage

// ===== sv/srr_cfg.sv =====
module srr_cfg (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [5:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output srr_pkg::cfg_t cfg
);

    srr_pkg::cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx = paddr[5:3];
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal <= 24'd184027;
            cfg_reg.px    <= 24'd155441;
            cfg_reg.py    <= 24'd47415;
            cfg_reg.off   <= -24'sd98853;
            cfg_reg.rot0  <= 54'd65536;
            cfg_reg.rot1  <= 54'd65536 << 18;
            cfg_reg.rot2  <= 54'd65536 << 36;
            cfg_reg.trans <= '0;
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0)
        begin
            case (idx)
                srr_pkg::AddrFocal: cfg_reg.focal <= pwdata[23:0];
                srr_pkg::AddrPx:    cfg_reg.px    <= pwdata[23:0];
                srr_pkg::AddrPy:    cfg_reg.py    <= pwdata[23:0];
                srr_pkg::AddrOff:   cfg_reg.off   <= pwdata[23:0];
                srr_pkg::AddrRot0:  cfg_reg.rot0  <= pwdata[53:0];
                srr_pkg::AddrRot1:  cfg_reg.rot1  <= pwdata[53:0];
                srr_pkg::AddrRot2:  cfg_reg.rot2  <= pwdata[53:0];
                srr_pkg::AddrTrans: cfg_reg.trans <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            srr_pkg::AddrFocal: prdata = {40'd0, cfg_reg.focal};
            srr_pkg::AddrPx:    prdata = {40'd0, cfg_reg.px};
            srr_pkg::AddrPy:    prdata = {40'd0, cfg_reg.py};
            srr_pkg::AddrOff:   prdata = {40'd0, cfg_reg.off};
            srr_pkg::AddrRot0:  prdata = {10'd0, cfg_reg.rot0};
            srr_pkg::AddrRot1:  prdata = {10'd0, cfg_reg.rot1};
            srr_pkg::AddrRot2:  prdata = {10'd0, cfg_reg.rot2};
            srr_pkg::AddrTrans: prdata = {1'b0, cfg_reg.trans};
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== sv/srr_xform.sv =====
// Camera-frame coordinate: three products registered, then summed and rounded.
module srr_xform (
    input  logic clk,
    input  logic en,
    input  logic [53:0] row,
    input  logic signed [20:0] tr,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    input  logic signed [31:0] z,
    output logic signed [srr_pkg::CoordW-1:0] c
);

    localparam int CoordW = srr_pkg::CoordW;

    logic signed [49:0] p0_reg, p1_reg, p2_reg;
    logic signed [20:0] t_reg;
    logic signed [52:0] acc;
    logic signed [CoordW-1:0] c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= $signed(row[17:0]) * x;
            p1_reg <= $signed(row[35:18]) * y;
            p2_reg <= $signed(row[53:36]) * z;
            t_reg  <= tr;
        end
    end

    assign acc = 53'(p0_reg) + 53'(p1_reg) + 53'(p2_reg)
               + (53'(t_reg) <<< 16) + 53'sd32768;

    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= CoordW'(acc >>> 16);
    end

    assign c = c_reg;

endmodule

// ===== sv/srr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(num / (2*den)) on magnitudes.
module srr_div (
    input  logic clk,
    input  logic en,
    input  logic [srr_pkg::NumW-1:0] num,
    input  logic [srr_pkg::CoordW-1:0] den,
    output logic [srr_pkg::QuotW-1:0] quo
);

    localparam int N = srr_pkg::NumW;
    localparam int D = srr_pkg::CoordW + 1;

    logic [N-1:0] q_reg [0:N];
    logic [D-1:0] r_reg [0:N];
    logic [D-1:0] d_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= num;
            r_reg[0] <= '0;
            d_reg[0] <= {den, 1'b0};
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_st
        logic [D:0] sh;
        logic [D:0] df;
        assign sh = {r_reg[i], q_reg[i][N-1]};
        assign df = sh - {1'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[i+1] <= d_reg[i];
                if (!df[D])
                begin
                    r_reg[i+1] <= df[D-1:0];
                    q_reg[i+1] <= {q_reg[i][N-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i+1] <= sh[D-1:0];
                    q_reg[i+1] <= {q_reg[i][N-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[N];

endmodule

// ===== sv/stereo_reprojection_residual.sv =====
// Throughput: one transaction per cycle while not stalled; the 72-stage divider pipelines set latency.
// A stall freezes the whole pipeline; the output register holds its result.
// Reset (rst_n, asynchronous, active low) clears all valid bits and loads
// the register defaults: identity rotation, zero translation.
module stereo_reprojection_residual (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [5:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic pready,
    input  logic valid_in,
    output logic stall_in,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] obs_left_u,
    input  logic signed [31:0] obs_left_v,
    input  logic signed [31:0] obs_right_u,
    input  logic signed [31:0] obs_right_v,
    input  logic last_point,
    output logic valid_out,
    input  logic stall_out,
    output logic signed [31:0] res_left_u,
    output logic signed [31:0] res_left_v,
    output logic signed [31:0] res_right_u,
    output logic signed [31:0] res_right_v,
    output logic depth_invalid,
    output logic saturated,
    output logic last_result
);

    localparam int CW = srr_pkg::CoordW;
    localparam int NW = srr_pkg::NumW;
    localparam int Lat = 3 + NW + 2;

    srr_pkg::cfg_t cfg;
    logic en;
    logic [Lat-1:0] v_reg;
    srr_pkg::side_t side_reg [0:Lat-1];
    logic signed [CW-1:0] cx, cy, cz;

    assign pready = 1'b1;
    assign en = !(valid_out && stall_out);
    assign stall_in = !en;

    srr_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
    );

    srr_xform u_x (.clk(clk), .en(en), .row(cfg.rot0), .tr(cfg.trans[20:0]),
        .x(point_x), .y(point_y), .z(point_z), .c(cx));
    srr_xform u_y (.clk(clk), .en(en), .row(cfg.rot1), .tr(cfg.trans[41:21]),
        .x(point_x), .y(point_y), .z(point_z), .c(cy));
    srr_xform u_z (.clk(clk), .en(en), .row(cfg.rot2), .tr(cfg.trans[62:42]),
        .x(point_x), .y(point_y), .z(point_z), .c(cz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[Lat-2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {obs_left_u, obs_left_v, obs_right_u, obs_right_v, last_point};
            for (int i = 1; i < Lat; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Stage 3: numerators f*c (wide products, registered) with signs split off.
    logic signed [NW-1:0] nx_reg, ny_reg, nr_reg;
    logic [CW-1:0] dz_reg;
    logic inv_reg;
    logic signed [NW-1:0] nx, ny, nr;

    assign nx = NW'(cx) * $signed({1'b0, cfg.focal});
    assign ny = NW'(cy) * $signed({1'b0, cfg.focal});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nx;
            ny_reg  <= ny;
            nr_reg  <= nx + (NW'(cfg.off) <<< 16);
            dz_reg  <= cz[CW-1] ? '0 : cz;
            inv_reg <= (cz[CW-1] || cz == '0);
        end
    end

    logic [NW-1:0] mx, my, mr, qx, qy, qr;
    assign mx = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
    assign my = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
    assign mr = nr_reg[NW-1] ? NW'(-nr_reg) : NW'(nr_reg);

    // The divider sees 2n+d over 2d; fold the +d into the numerator path.
    logic [NW-1:0] ax, ay, ar;
    assign ax = NW'(({1'b0, mx} << 1) + NW'(dz_reg)) ;
    assign ay = NW'(({1'b0, my} << 1) + NW'(dz_reg));
    assign ar = NW'(({1'b0, mr} << 1) + NW'(dz_reg));

    srr_div u_dx (.clk(clk), .en(en), .num(ax), .den(dz_reg), .quo(qx));
    srr_div u_dy (.clk(clk), .en(en), .num(ay), .den(dz_reg), .quo(qy));
    srr_div u_dr (.clk(clk), .en(en), .num(ar), .den(dz_reg), .quo(qr));

    logic [NW:0] sgn_reg [0:2];
    logic [NW:0] inv_pipe;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_reg[0] <= {sgn_reg[0][NW-1:0], nx_reg[NW-1]};
            sgn_reg[1] <= {sgn_reg[1][NW-1:0], ny_reg[NW-1]};
            sgn_reg[2] <= {sgn_reg[2][NW-1:0], nr_reg[NW-1]};
            inv_pipe   <= {inv_pipe[NW-1:0], inv_reg};
        end
    end

    // Final stage: signs, principal point, observation, saturation.
    logic signed [NW+1:0] lu, lv, ru, d0, d1, d2, d3;
    srr_pkg::side_t so;
    assign so = side_reg[Lat-2];
    assign lu = (sgn_reg[0][NW] ? -$signed({2'b0, qx}) : $signed({2'b0, qx}))
              + (NW+2)'(cfg.px);
    assign lv = (sgn_reg[1][NW] ? -$signed({2'b0, qy}) : $signed({2'b0, qy}))
              + (NW+2)'(cfg.py);
    assign ru = (sgn_reg[2][NW] ? -$signed({2'b0, qr}) : $signed({2'b0, qr}))
              + (NW+2)'(cfg.px);
    assign d0 = lu - (NW+2)'(so.ou);
    assign d1 = lv - (NW+2)'(so.ov);
    assign d2 = ru - (NW+2)'(so.oru);
    assign d3 = lv - (NW+2)'(so.orv);

    function automatic logic [32:0] clip(input logic signed [NW+1:0] v);
        logic [32:0] r;
        if (v > (NW+2)'(64'sd2147483647))
            r = {1'b1, 32'h7fffffff};
        else if (v < -(NW+2)'(64'sd2147483648))
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    logic [32:0] c0, c1, c2, c3;
    assign c0 = clip(d0);
    assign c1 = clip(d1);
    assign c2 = clip(d2);
    assign c3 = clip(d3);

    logic bad;
    assign bad = inv_pipe[NW];

    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic inv_o_reg, sat_reg, last_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg    <= bad ? '0 : c0[31:0];
            r1_reg    <= bad ? '0 : c1[31:0];
            r2_reg    <= bad ? '0 : c2[31:0];
            r3_reg    <= bad ? '0 : c3[31:0];
            sat_reg   <= !bad && (c0[32] || c1[32] || c2[32] || c3[32]);
            inv_o_reg <= bad;
            last_reg  <= so.last;
        end
    end

    assign valid_out     = v_reg[Lat-1];
    assign res_left_u    = r0_reg;
    assign res_left_v    = r1_reg;
    assign res_right_u   = r2_reg;
    assign res_right_v   = r3_reg;
    assign depth_invalid = inv_o_reg;
    assign saturated     = sat_reg;
    assign last_result   = last_reg;

endmodule

// ===== sv/srr_checker.sv =====
module srr_checker (
    input logic clk,
    input logic rst_n,
    input logic valid_out,
    input logic stall_out,
    input logic stall_in,
    input logic depth_invalid,
    input logic saturated,
    input logic [31:0] res_left_u
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && stall_out |=> valid_out && $stable(res_left_u))
        else $error("stalled result changed");

    a_inv_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && depth_invalid |-> !saturated && res_left_u == 32'd0)
        else $error("invalid depth with nonzero result");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stall_in |-> valid_out && stall_out)
        else $error("input stalled without output stall");

endmodule

bind stereo_reprojection_residual srr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .valid_out(valid_out), .stall_out(stall_out),
    .stall_in(stall_in), .depth_invalid(depth_invalid), .saturated(saturated),
    .res_left_u(res_left_u)
);
